// ===== rtl/core/wto_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_pkg
// Shared widths, constants, codes and the voice record of the wavetable
// oscillator bank.
// ----------------------------------------------------------------------------
package wto_pkg;

	localparam int VOICES_DEF   = 64;
	localparam int TABLE_SIZE   = 514;
	localparam int TAW          = 10;
	localparam int WAVE_W       = 16;
	localparam int PHASE_W      = 25;
	localparam int RATE_W       = 14;
	localparam int LEVEL_W      = 16;
	localparam int STEP_W       = 24;
	localparam int STEP_PER_HZ  = 761;
	localparam int WRAP_AT      = 511 * 65536;
	localparam int WRAP_BY      = 512 * 65536;
	localparam int TERM_W       = 49;
	localparam int VOLUME_W     = 11;
	localparam int VOLUME_RESET = 870;
	localparam int SAMPLE_W     = 16;

	typedef enum logic [1:0] {
		ACT_TABLE  = 2'd0,
		ACT_VOICE  = 2'd1,
		ACT_SAMPLE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_PLAY   = 2'd0,
		REG_VOLUME = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [RATE_W-1:0]  rate;
		logic [LEVEL_W-1:0] level;
	} voice_t;

endpackage

// ===== rtl/core/wavetable_oscillator_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator_bank
// Bank of wavetable oscillators sharing one interpolated wave table, mixed
// into one Q1.15 sample per request.
// ----------------------------------------------------------------------------
// After reset the block zeroes the wave table and voice store, with
// s_tready low; configuration writes are taken throughout. A table write
// or an unused action leaves the input ready, a voice set passes through
// a set state (read, modify and write back of the voice entry). With the
// oscillators running, a sample request reads the voice store one voice per
// cycle into a phase, interpolate and weight pipeline whose terms are
// accumulated, followed by the four-stage output scaler. With the play
// register clear a request gives silence without running the voices. The
// result waits in an output register; further table and voice transfers are
// taken while it waits.
// ----------------------------------------------------------------------------
module wavetable_oscillator_bank #(
	parameter int VOICES = wto_pkg::VOICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// table_index[9:0], table_value[25:10], voice_index[31:26],
	// voice_frequency[45:32], voice_amplitude[61:46], zero[63:62]
	input  logic [63:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sample[15:0]
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int ACC_W = wto_pkg::TERM_W + VW + 1;
	localparam logic [VW-1:0] VLAST = VW'(VOICES - 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SET   = 7'b0000100,
		ST_RUN   = 7'b0001000,
		ST_DRAIN = 7'b0010000,
		ST_MIX   = 7'b0100000,
		ST_PUSH  = 7'b1000000
	} state_t;

	state_t state_q;

	// input fields
	logic [9:0]         in_tidx;
	logic signed [15:0] in_tval;
	logic [5:0]         in_vidx;
	logic [13:0]        in_freq;
	logic [15:0]        in_amp;
	logic [8:0]         in_vidx_ext;
	logic               vidx_ok;
	logic               tidx_ok;
	logic               s_accept;

	assign in_tidx     = s_tdata[9:0];
	assign in_tval     = s_tdata[25:10];
	assign in_vidx     = s_tdata[31:26];
	assign in_freq     = s_tdata[45:32];
	assign in_amp      = s_tdata[61:46];
	assign in_vidx_ext = {3'b000, in_vidx};
	assign vidx_ok     = in_vidx_ext < 9'(VOICES);
	assign tidx_ok     = in_tidx < 10'(wto_pkg::TABLE_SIZE);
	assign s_tready    = (state_q == ST_IDLE);
	assign s_accept    = s_tvalid & s_tready;
	assign cfg_ready   = 1'b1;

	// configuration
	logic                          play_q;
	logic [wto_pkg::VOLUME_W-1:0]  volume_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q   <= 1'b0;
			volume_q <= 11'(wto_pkg::VOLUME_RESET);
		end else if (cfg_valid) begin
			case (wto_pkg::reg_index_t'(cfg_index))
				wto_pkg::REG_PLAY: begin
					play_q <= cfg_data[0];
				end
				wto_pkg::REG_VOLUME: begin
					volume_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// control
	logic [9:0]       clr_q;
	logic [VW-1:0]    n_q;
	logic             silent_q;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;
	logic [VW-1:0]    set_addr_q;
	logic [13:0]      set_rate_q;
	logic [15:0]      set_level_q;
	logic             pipe_busy;
	logic             mix_start;
	logic             mix_valid;
	logic [15:0]      mix_sample;
	logic             push;

	assign mix_start = (state_q == ST_DRAIN) && !pipe_busy;
	assign push      = (state_q == ST_PUSH) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			n_q        <= '0;
			silent_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == 10'(wto_pkg::TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 10'd1;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						case (wto_pkg::action_t'(s_tuser))
							wto_pkg::ACT_VOICE: begin
								if (vidx_ok) begin
									state_q <= ST_SET;
								end
							end
							wto_pkg::ACT_SAMPLE: begin
								silent_q <= !play_q;
								n_q      <= '0;
								state_q  <= play_q ? ST_RUN : ST_PUSH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SET: begin
					state_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (n_q == VLAST) begin
						state_q <= ST_DRAIN;
					end else begin
						n_q <= n_q + VW'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (mix_valid) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			set_addr_q  <= in_vidx_ext[VW-1:0];
			set_rate_q  <= in_freq;
			set_level_q <= in_amp;
		end
		if (push) begin
			m_tdata_q <= silent_q ? 16'd0 : mix_sample;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// voice store
	logic            v_we;
	logic [VW-1:0]   v_waddr;
	wto_pkg::voice_t v_wdata;
	logic [VW-1:0]   v_raddr;
	wto_pkg::voice_t v_rdata;

	// voice pipeline
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [VW-1:0]      addr_s1, addr_s2;
	logic [23:0]        step_s2;
	logic [24:0]        phase_s2;
	logic [13:0]        rate_s2;
	logic [15:0]        level_s2, level_s3, level_s4, level_s5, level_s6;
	logic [15:0]        r_s3, r_s4;
	logic signed [16:0] d_s4;
	logic signed [15:0] a_s4, a_s5;
	logic signed [33:0] prod_s5;
	logic signed [32:0] interp_s6;
	logic signed [48:0] term_s7;
	logic signed [ACC_W-1:0] acc_q;

	logic [23:0]        step_c;
	logic [25:0]        sum_c;
	logic [26:0]        diff_c;
	logic [24:0]        new_phase_c;
	logic [9:0]         t_raddr_a, t_raddr_b;
	logic signed [15:0] t_rdata_a, t_rdata_b;
	logic signed [33:0] interp_c;
	logic signed [49:0] term_c;

	assign v_raddr = (state_q == ST_RUN) ? n_q : in_vidx_ext[VW-1:0];

	always_comb begin
		v_we    = vld_s2;
		v_waddr = addr_s2;
		v_wdata = '{phase: new_phase_c, rate: rate_s2, level: level_s2};
		if (state_q == ST_CLEAR) begin
			v_we    = clr_q < 10'(VOICES);
			v_waddr = clr_q[VW-1:0];
			v_wdata = '0;
		end else if (state_q == ST_SET) begin
			v_we    = 1'b1;
			v_waddr = set_addr_q;
			v_wdata = '{phase: v_rdata.phase, rate: set_rate_q, level: set_level_q};
		end
	end

	wto_voice_mem #(
		.DEPTH (VOICES),
		.AW    (VW)
	) u_voice_mem (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// wave table
	logic              t_we;
	logic [9:0]        t_waddr;
	logic signed [15:0] t_wdata;

	always_comb begin
		t_we    = 1'b0;
		t_waddr = in_tidx;
		t_wdata = in_tval;
		if (state_q == ST_CLEAR) begin
			t_we    = 1'b1;
			t_waddr = clr_q;
			t_wdata = '0;
		end else if (s_accept && (s_tuser == wto_pkg::ACT_TABLE) && tidx_ok) begin
			t_we = 1'b1;
		end
	end

	wto_table_mem u_table_mem (
		.clk     (clk),
		.we      (t_we),
		.waddr   (t_waddr),
		.wdata   (t_wdata),
		.raddr_a (t_raddr_a),
		.raddr_b (t_raddr_b),
		.rdata_a (t_rdata_a),
		.rdata_b (t_rdata_b)
	);

	assign step_c = 24'(v_rdata.rate) * 24'(wto_pkg::STEP_PER_HZ);

	// phase advance and wrap, written back in the same stage
	assign sum_c  = 26'(phase_s2) + 26'(step_s2);
	assign diff_c = {1'b0, sum_c} - 27'(wto_pkg::WRAP_BY);

	always_comb begin
		if (sum_c >= 26'(wto_pkg::WRAP_AT)) begin
			new_phase_c = diff_c[26] ? 25'd0 : diff_c[24:0];
		end else begin
			new_phase_c = sum_c[24:0];
		end
	end

	assign t_raddr_a = {1'b0, new_phase_c[24:16]} + 10'd1;
	assign t_raddr_b = {1'b0, new_phase_c[24:16]} + 10'd2;

	// (65536 - r) * a + r * b rewritten as a * 65536 + r * (b - a)
	assign interp_c = {{2{a_s5[15]}}, a_s5, 16'd0} + prod_s5;
	assign term_c   = interp_s6 * $signed({1'b0, level_s6});

	assign pipe_busy = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5 | vld_s6 | vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= n_q;
		addr_s2   <= addr_s1;
		step_s2   <= step_c;
		phase_s2  <= v_rdata.phase;
		rate_s2   <= v_rdata.rate;
		level_s2  <= v_rdata.level;
		r_s3      <= new_phase_c[15:0];
		level_s3  <= level_s2;
		d_s4      <= {t_rdata_b[15], t_rdata_b} - {t_rdata_a[15], t_rdata_a};
		a_s4      <= t_rdata_a;
		r_s4      <= r_s3;
		level_s4  <= level_s3;
		prod_s5   <= $signed({1'b0, r_s4}) * d_s4;
		a_s5      <= a_s4;
		level_s5  <= level_s4;
		interp_s6 <= interp_c[32:0];
		level_s6  <= level_s5;
		term_s7   <= term_c[48:0];
		if (s_accept && (s_tuser == wto_pkg::ACT_SAMPLE)) begin
			acc_q <= '0;
		end else if (vld_s7) begin
			acc_q <= acc_q + {{(ACC_W - wto_pkg::TERM_W){term_s7[48]}}, term_s7};
		end
	end

	wto_mix #(
		.ACC_W (ACC_W)
	) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.acc    (acc_q),
		.volume (volume_q),
		.valid  (mix_valid),
		.sample (mix_sample)
	);

endmodule

// ===== rtl/core/wto_voice_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_voice_mem
// Per-voice phase, rate and level store, one write and one registered read.
// ----------------------------------------------------------------------------
module wto_voice_mem #(
	parameter int DEPTH = wto_pkg::VOICES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  wto_pkg::voice_t wdata,
	input  logic [AW-1:0]   raddr,
	output wto_pkg::voice_t rdata
);

	wto_pkg::voice_t mem [DEPTH];
	wto_pkg::voice_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

// ===== rtl/core/wto_table_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_table_mem
// Shared wave table, one write port and two registered read ports for the
// pair of neighbouring entries used by the interpolator.
// ----------------------------------------------------------------------------
module wto_table_mem (
	input  logic                                clk,
	input  logic                                we,
	input  logic [wto_pkg::TAW-1:0]             waddr,
	input  logic signed [wto_pkg::WAVE_W-1:0]   wdata,
	input  logic [wto_pkg::TAW-1:0]             raddr_a,
	input  logic [wto_pkg::TAW-1:0]             raddr_b,
	output logic signed [wto_pkg::WAVE_W-1:0]   rdata_a,
	output logic signed [wto_pkg::WAVE_W-1:0]   rdata_b
);

	logic signed [wto_pkg::WAVE_W-1:0] mem [wto_pkg::TABLE_SIZE];
	logic signed [wto_pkg::WAVE_W-1:0] rd_a_q;
	logic signed [wto_pkg::WAVE_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== rtl/core/wto_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_mix
// Output stage: clamps the voice sum to plus or minus 20.0, applies volume,
// divides by 20 with rounding and saturates to Q1.15. Four stages.
// ----------------------------------------------------------------------------
module wto_mix #(
	parameter int ACC_W = wto_pkg::TERM_W + 7
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [ACC_W-1:0]              acc,
	input  logic [wto_pkg::VOLUME_W-1:0]         volume,
	output logic                                 valid,
	output logic [wto_pkg::SAMPLE_W-1:0]         sample
);

	localparam int CW = (ACC_W > 54) ? ACC_W : 54;
	localparam logic signed [CW-1:0] LIM = CW'(64'd20 << 47);
	localparam logic [63:0] HALF = 64'd10 << 42;
	localparam logic [17:0] U_MAX = 18'd163840;
	localparam logic [36:0] RECIP5 = 37'd419431;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [53:0] clamp_s1;
	logic signed [63:0] y_s2;
	logic [17:0]        u_s3;
	logic               neg_s3;
	logic [15:0]        sample_s4;

	logic signed [CW-1:0] acc_x;
	logic signed [CW-1:0] clamp_c;
	logic signed [63:0]   y_c;
	logic [63:0]          mag_c;
	logic [63:0]          rnd_c;
	logic [19:0]          u_full_c;
	logic [36:0]          prod_c;
	logic [15:0]          q_c;
	logic [15:0]          res_c;

	assign acc_x = CW'(acc);

	always_comb begin
		if (acc_x > LIM) begin
			clamp_c = LIM;
		end else if (acc_x < -LIM) begin
			clamp_c = -LIM;
		end else begin
			clamp_c = acc_x;
		end
	end

	assign y_c = clamp_s1 * $signed({1'b0, volume});

	// magnitude, round half away from zero, then divide by 4 * 2^42
	assign mag_c    = y_s2[63] ? 64'(-y_s2) : 64'(y_s2);
	assign rnd_c    = mag_c + HALF;
	assign u_full_c = rnd_c[63:44];

	// divide by 5 through a reciprocal, exact below 2^18
	assign prod_c = 37'(u_s3) * RECIP5;
	assign q_c    = prod_c[36:21];

	always_comb begin
		if (neg_s3) begin
			res_c = (q_c > 16'd32768) ? 16'h8000 : 16'(16'd0 - q_c);
		end else begin
			res_c = (q_c > 16'd32767) ? 16'd32767 : q_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			clamp_s1 <= clamp_c[53:0];
		end
		if (v_s1) begin
			y_s2 <= y_c;
		end
		if (v_s2) begin
			neg_s3 <= y_s2[63];
			u_s3   <= (u_full_c >= 20'(U_MAX)) ? U_MAX : u_full_c[17:0];
		end
		if (v_s3) begin
			sample_s4 <= res_c;
		end
	end

	assign valid  = v_s4;
	assign sample = sample_s4;

endmodule

// ===== rtl/core/wto_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_checker
// Port-level checks on the oscillator bank, bound to the top level.
// ----------------------------------------------------------------------------
module wto_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a new result only comes out of a busy cycle
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// a sample request occupies the block
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == wto_pkg::ACT_SAMPLE) |=> !s_tready)
		else $error("input taken during a sample request");

	// a table write transfer leaves the input ready
	a_table_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == wto_pkg::ACT_TABLE) |=> s_tready)
		else $error("table write stalled the input");

endmodule

bind wavetable_oscillator_bank wto_checker u_wto_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wavetable oscillator bank: a scoreboard keeps
// its own copy of the table, voices and registers, predicts each mixed sample
// and compares it with every sample transfer, under varied back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import wto_pkg::*;

	localparam int NVOICES = VOICES_DEF;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = NVOICES + 40;
	localparam int BLOCKS = 12;
	localparam int BLOCK_ITEMS = 128;

	class osc_mix_scoreboard;
		logic [PHASE_W-1:0] phase [NVOICES];
		logic [RATE_W-1:0] rate [NVOICES];
		logic [LEVEL_W-1:0] level [NVOICES];
		logic signed [WAVE_W-1:0] wave [TABLE_SIZE];
		bit play;
		logic [VOLUME_W-1:0] vol;
		logic [SAMPLE_W-1:0] expected_samples [$];
		int mismatches;
		int samples_checked;
		int table_writes;
		int voice_sets;

		function new();
			foreach (phase[n]) begin
				phase[n] = '0;
				rate[n] = '0;
				level[n] = '0;
			end
			foreach (wave[k])
				wave[k] = '0;
			play = 1'b0;
			vol = VOLUME_W'(VOLUME_RESET);
			mismatches = 0;
			samples_checked = 0;
			table_writes = 0;
			voice_sets = 0;
		endfunction

		function void apply_config(logic [1:0] idx, logic [10:0] data);
			case (idx)
				REG_PLAY: play = data[0];
				REG_VOLUME: vol = data;
				default: ;
			endcase
		endfunction

		// advances every phase and returns the scaled, clamped mix
		function logic [SAMPLE_W-1:0] predict_mix();
			longint acc, ph, r, a, b, y, lim, div, mag, q, res;
			int ip;
			acc = 0;
			for (int n = 0; n < NVOICES; n++) begin
				ph = longint'(phase[n]) + longint'(rate[n]) * STEP_PER_HZ;
				if (ph >= WRAP_AT)
					ph -= WRAP_BY;
				if (ph < 0)
					ph = 0;
				phase[n] = ph[PHASE_W-1:0];
				ip = phase[n][PHASE_W-1:16];
				r = longint'(phase[n][15:0]);
				a = wave[ip + 1];
				b = wave[ip + 2];
				acc += ((65536 - r) * a + r * b) * longint'(level[n]);
			end
			lim = longint'(20) << 47;
			div = longint'(20) << 42;
			if (acc > lim)
				acc = lim;
			if (acc < -lim)
				acc = -lim;
			y = acc * longint'(vol);
			mag = (y < 0) ? -y : y;
			q = (mag + div / 2) / div;
			if (y < 0) begin
				if (q > 32768)
					q = 32768;
				res = -q;
			end else begin
				if (q > 32767)
					q = 32767;
				res = q;
			end
			return res[SAMPLE_W-1:0];
		endfunction

		function void note_item(logic [1:0] action, logic [63:0] data);
			logic [SAMPLE_W-1:0] want;
			case (action)
				ACT_TABLE: begin
					if (data[9:0] < TABLE_SIZE)
						wave[data[9:0]] = data[25:10];
					table_writes++;
				end
				ACT_VOICE: begin
					if (data[31:26] < NVOICES) begin
						rate[data[31:26]] = data[45:32];
						level[data[31:26]] = data[61:46];
					end
					voice_sets++;
				end
				ACT_SAMPLE: begin
					want = play ? predict_mix() : '0;
					expected_samples.insert(expected_samples.size(), want);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH: %s", msg);
		endtask

		task check_sample(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %0d with no request pending", $signed(got)));
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (got !== want)
					report($sformatf("sample %0d: got %0d, expected %0d",
						samples_checked, $signed(got), $signed(want)));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	int src_idle_pct;
	int sink_idle_pct;
	osc_mix_scoreboard sb;

	wavetable_oscillator_bank dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// input transfers are noted before results of the same edge are checked
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(m_tdata);
		if (arst_n && cfg_valid && cfg_ready)
			sb.apply_config(cfg_index, cfg_data);
	end

	function automatic logic [63:0] pack_item(logic [9:0] idx, logic [15:0] val,
			logic [5:0] vi, logic [13:0] freq, logic [15:0] amp);
		return {2'b00, amp, freq, vi, val, idx};
	endfunction

	task automatic send_item(logic [1:0] action, logic [63:0] data);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// table and voice transfers give no result, so allow a mix to finish too
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_item();
		logic [9:0] idx;
		logic [15:0] val;
		logic [5:0] vi;
		logic [13:0] freq;
		logic [15:0] amp;
		int pick;
		idx = 10'($urandom);
		val = 16'($urandom);
		vi = 6'($urandom);
		freq = 14'($urandom);
		amp = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			if ($urandom_range(0, 9) != 0)
				idx = 10'($urandom_range(0, TABLE_SIZE - 1));
			send_item(ACT_TABLE, pack_item(idx, val, vi, freq, amp));
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: freq = 14'($urandom_range(0, 100));
				1, 2: freq = 14'($urandom_range(0, 12000));
				default: ;
			endcase
			amp = amp >> $urandom_range(0, 12);
			send_item(ACT_VOICE, pack_item(idx, val, vi, freq, amp));
		end else if (pick < 95) begin
			send_item(ACT_SAMPLE, pack_item(idx, val, vi, freq, amp));
		end else begin
			send_item(ACT_NONE, pack_item(idx, val, vi, freq, amp));
		end
	endtask

	initial begin
		logic [63:0] noise;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_TABLE;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PLAY;
		cfg_data = '0;
		src_idle_pct = 15;
		sink_idle_pct = 75;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// silence while stopped, an unused action, table and voice extremes
		send_item(ACT_SAMPLE, '0);
		noise = {2'b00, 62'($urandom) << 32 | 62'($urandom)};
		send_item(ACT_NONE, noise);
		send_item(ACT_TABLE, pack_item(10'd0, 16'sh8000, '0, '0, '0));
		send_item(ACT_TABLE, pack_item(10'd1, 16'sh8000, '0, '0, '0));
		send_item(ACT_TABLE, pack_item(10'd2, 16'sh7FFF, '0, '0, '0));
		send_item(ACT_TABLE, pack_item(10'd513, 16'sh7FFF, '0, '0, '0));
		send_item(ACT_TABLE, pack_item(10'd514, 16'sh7FFF, '0, '0, '0));
		send_item(ACT_TABLE, pack_item(10'd1023, 16'shFFFF, '1, '1, '1));
		send_item(ACT_TABLE, pack_item(10'd256, 16'($urandom), '0, '0, '0));
		send_item(ACT_VOICE, pack_item('0, '0, 6'd0, 14'd0, 16'hFFFF));
		send_item(ACT_VOICE, pack_item('1, '1, 6'd63, 14'h3FFF, 16'hFFFF));
		send_item(ACT_VOICE, pack_item('0, '0, 6'd1, 14'd12000, 16'd1));
		send_item(ACT_VOICE, pack_item('0, '0, 6'd2, 14'd1, 16'h8000));
		settle();
		write_reg(REG_PLAY, 11'd1);
		write_reg(REG_VOLUME, 11'd2047);
		repeat (3) send_item(ACT_SAMPLE, '0);
		settle();
		write_reg(REG_VOLUME, 11'd0);
		send_item(ACT_SAMPLE, '0);
		settle();
		write_reg(REG_VOLUME, 11'd1024);
		write_reg(REG_UNUSED, 11'd5);
		repeat (2) send_item(ACT_SAMPLE, '0);
		settle();
		// phases must hold while stopped
		write_reg(REG_PLAY, 11'd0);
		send_item(ACT_SAMPLE, '0);
		settle();
		write_reg(REG_PLAY, 11'd1);
		send_item(ACT_SAMPLE, '0);
		settle();

		for (int blk = 0; blk < BLOCKS; blk++) begin
			case (blk / 4)
				0: begin
					src_idle_pct = 15;
					sink_idle_pct = 75;
				end
				1: begin
					src_idle_pct = 75;
					sink_idle_pct = 15;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			write_reg(REG_PLAY, (blk % 4 == 3) ? 11'd0 : 11'd1);
			case (blk % 4)
				0: write_reg(REG_VOLUME, 11'd1024);
				2: write_reg(REG_VOLUME, 11'd2047);
				default: write_reg(REG_VOLUME, 11'($urandom_range(1, 2047)));
			endcase
			if (blk % 4 == 3)
				write_reg(REG_UNUSED, 11'($urandom));
			repeat (BLOCK_ITEMS) random_item();
			settle();
		end

		$display("checked %0d samples after %0d table writes and %0d voice settings",
			sb.samples_checked, sb.table_writes, sb.voice_sets);
		$display("covered stopped and running mixes, volume 0 to 2047, three stall patterns");
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout waiting for the bank");
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/wto_pkg.sv
rtl/core/wto_voice_mem.sv
rtl/core/wto_table_mem.sv
rtl/core/wto_mix.sv
rtl/core/wavetable_oscillator_bank.sv
rtl/core/wto_checker.sv
tb/sv/tb_top.sv
